// ===== hw/rtl/psfrl_pkg.sv =====
// shared types and constants for the per-source failure rate limiter
package psfrl_pkg;

  // table geometry
  localparam int TRACKERS_DEF = 8;

  // field widths
  localparam int ADDR_W = 32;
  localparam int TIME_W = 48;
  localparam int CNT_W  = 8;
  localparam int ATT_W  = 8;
  localparam int MIN_W  = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // window length in ms fits 1440 minutes of 60000 ms
  localparam int WIN_W = 27;

  // constants of the scheme
  localparam int unsigned MS_PER_MIN    = 60000;
  localparam int unsigned DEF_WINDOW_MS = 60000;
  localparam int unsigned DEF_ATTEMPTS  = 5;
  localparam int unsigned CNT_MAX       = 255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MINUTES = CFG_IDX_W'(1);

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] start;
  } entry_t;

endpackage

// ===== hw/rtl/per_source_fail_rate_limiter.sv =====
// per-source failure rate limiter: table memory, scan sequencer and update logic
// flow: one word at a time, taken only while idle: the accept, a scan of the table memory
//   one entry a cycle through its registered read, then an update that waits for a free output register;
//   a new input word is taken while the previous result still waits in the output register
// reset: synchronous; valid flops cleared so all entries read free; limit 5, block_minutes 1
module per_source_fail_rate_limiter
  import psfrl_pkg::*;
#(
  parameter int TRACKERS = TRACKERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input words
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [79:0]           s_tdata,   // source_addr[31:0], time_ms[79:32]
  input  logic                  s_tuser,   // mode
  // result words
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // allowed[0], tracked[1], fail_count[9:2], zero[15:10]
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACKERS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  logic [1:0]        state;

  // configuration
  logic [ATT_W-1:0]  attempt_limit;
  logic [MIN_W-1:0]  block_minutes;
  logic [WIN_W-1:0]  win_ms;
  logic [ATT_W-1:0]  limit;

  // request held during the scan
  logic              req_mode;
  logic [ADDR_W-1:0] req_addr;
  logic [TIME_W-1:0] req_time;

  // table memory and its valid flops
  entry_t            mem [TRACKERS];
  logic [TRACKERS-1:0] entry_valid;
  entry_t            rd_q;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  rd_ptr;
  logic              issue_done;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  entry_t            rd_entry;

  // scan results
  logic              match_found;
  logic [IDX_W-1:0]  match_idx;
  entry_t            match_entry;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  entry_t            free_entry;

  // update
  logic              mod_go;
  logic              sel_found;
  logic [IDX_W-1:0]  sel_idx;
  entry_t            sel_entry;
  entry_t            wr_entry;
  logic              res_allowed;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign mod_go    = (state == S_MOD) && (!m_tvalid || m_tready);
  assign limit     = (attempt_limit == '0) ? ATT_W'(DEF_ATTEMPTS) : attempt_limit;
  assign rd_entry  = rd_valid_q ? rd_q : '0;

  // configuration registers and window length
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit <= ATT_W'(DEF_ATTEMPTS);
      block_minutes <= MIN_W'(1);
      win_ms        <= WIN_W'(DEF_WINDOW_MS);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ATTEMPT_LIMIT: attempt_limit <= cfg_data[ATT_W-1:0];
          REG_BLOCK_MINUTES: block_minutes <= cfg_data[MIN_W-1:0];
          default: ;
        endcase
      end
      if (block_minutes == '0) begin
        win_ms <= WIN_W'(DEF_WINDOW_MS);
      end else begin
        win_ms <= WIN_W'(block_minutes) * WIN_W'(MS_PER_MIN);
      end
    end
  end

  // table memory: one read port, one write port
  always_ff @(posedge clk) begin
    rd_q       <= mem[rd_ptr];
    rd_valid_q <= entry_valid[rd_ptr];
    if (mod_go && sel_found) begin
      mem[sel_idx] <= wr_entry;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_mode <= s_tuser;
      req_addr <= s_tdata[31:0];
      req_time <= s_tdata[79:32];
    end
  end

  // sequencer: scan then update
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      rd_ptr      <= '0;
      issue_done  <= 1'b0;
      rd_vld      <= 1'b0;
      rd_idx      <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state       <= S_SCAN;
            rd_ptr      <= '0;
            issue_done  <= 1'b0;
            rd_vld      <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
          end
        end
        S_SCAN: begin
          // issue one read a cycle
          rd_vld <= !issue_done;
          rd_idx <= rd_ptr;
          if (!issue_done) begin
            if (rd_ptr == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              rd_ptr <= rd_ptr + IDX_W'(1);
            end
          end
          // first match and first free entry
          if (rd_vld) begin
            if (!match_found && rd_entry.addr == req_addr) begin
              match_found <= 1'b1;
              match_idx   <= rd_idx;
              match_entry <= rd_entry;
            end
            if (!free_found && rd_entry.addr == '0) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
              free_entry <= rd_entry;
            end
            if (rd_idx == LAST_IDX) begin
              state  <= S_MOD;
              rd_vld <= 1'b0;
            end
          end
        end
        S_MOD: begin
          if (mod_go) begin
            state <= S_IDLE;
            if (sel_found) begin
              entry_valid[sel_idx] <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // entry update
  always_comb begin
    logic [CNT_W-1:0]  cnt0;
    logic [TIME_W-1:0] start0;
    logic [TIME_W-1:0] diff;
    logic              expired;
    sel_found = match_found || free_found;
    sel_idx   = match_found ? match_idx : free_idx;
    sel_entry = match_found ? match_entry : free_entry;
    wr_entry.addr = req_addr;
    cnt0   = sel_entry.cnt;
    start0 = sel_entry.start;
    // claiming a free entry starts afresh
    if (sel_entry.addr != req_addr) begin
      cnt0   = '0;
      start0 = req_time;
    end
    diff    = req_time - start0;
    expired = diff > TIME_W'(win_ms);
    if (req_mode) begin
      wr_entry.cnt   = (sel_entry.cnt == CNT_W'(CNT_MAX)) ? sel_entry.cnt
                                                          : sel_entry.cnt + CNT_W'(1);
      wr_entry.start = req_time;
      res_allowed    = 1'b0;
    end else begin
      wr_entry.cnt   = expired ? '0 : cnt0;
      wr_entry.start = expired ? req_time : start0;
      res_allowed    = (wr_entry.cnt < limit);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (mod_go) begin
        m_tvalid <= 1'b1;
        if (sel_found) begin
          m_tdata <= {6'b0, wr_entry.cnt, 1'b1, res_allowed};
        end else begin
          m_tdata <= '0;
        end
      end
    end
  end

  // an allowed result is always a tracked one
  a_allowed_tracked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("allowed without a tracked entry");

  // an untracked result carries no count
  a_untracked_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[9:2] == '0)
    else $error("untracked result with nonzero count");

  // an accepted word starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_SCAN)
    else $error("accepted word did not start a scan");

  // an update always hands over a result
  a_mod_result: assert property (@(posedge clk) disable iff (rst)
    mod_go |=> m_tvalid)
    else $error("update without result");

endmodule
